FILE: src/tsm_pkg.sv
// Shared types, codes and defaults for the timestamp merge block.
package tsm_pkg;

   localparam int SourceSlotsDef = 4;
   localparam int QueueDepthDef  = 8;
   localparam int MaxEmit        = 32;
   localparam int EmitW          = $clog2(MaxEmit + 1);

   localparam logic [1:0] KindComplex = 2'd0;
   localparam logic [1:0] KindPulse   = 2'd1;
   localparam logic [1:0] KindEnd     = 2'd2;

   localparam logic OpOpen   = 1'b0;
   localparam logic OpAppend = 1'b1;

   localparam logic RkEvent = 1'b0;
   localparam logic RkClose = 1'b1;

   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StFull     = 2'd1;
   localparam logic [1:0] StInactive = 2'd2;
   localparam logic [1:0] StOpen     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_PASS,
      ST_CHECK,
      ST_WAIT_OUT,
      ST_FETCH,
      ST_WAIT_LAST
   } state_type;

   typedef struct packed {
      logic [31:0] time_v;
      logic [15:0] tag;
      logic [1:0]  kind;
   } entry_type;

   // One blocking test: another slot against the candidate head time.
   typedef struct packed {
      logic        active;
      logic        empty;
      logic [31:0] start_time;
      logic [31:0] head_time;
      logic [31:0] cand_time;
   } cmp_req_type;

endpackage

FILE: src/tsm_entry_mem.sv
// Event queue storage, one row of entries per source slot, registered read.
module tsm_entry_mem
   import tsm_pkg::*;
#(
   parameter int SLOTS = SourceSlotsDef,
   parameter int DEPTH = QueueDepthDef,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int PW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_slot,
   input  logic [PW-1:0] wr_ptr,
   input  entry_type     wr_data,
   input  logic [SW-1:0] rd_slot,
   input  logic [PW-1:0] rd_ptr,
   output entry_type     rd_data
);

   entry_type mem [SLOTS][DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot][wr_ptr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_slot][rd_ptr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tsm_blk_cmp.sv
// Shared compare unit: does one other slot hold back the candidate event.
module tsm_blk_cmp
   import tsm_pkg::*;
(
   input  cmp_req_type req,
   output logic        blocks
);

   always_comb begin
      if (!req.active) begin
         blocks = 1'b0;
      end else if (req.empty) begin
         blocks = (req.start_time <= req.cand_time);
      end else begin
         blocks = (req.cand_time > req.head_time);
      end
   end

endmodule

FILE: src/timestamp_merge_with_watermarks_core.sv
// Top level: k-way timestamp merge of per-source queues with pulse watermarks.
// Flow: an apply step, then passes over the slots; a complex head that is tried is compared
// against each other slot in turn, and a release waits for the output (plus stalls), then fetches the next head.
// One item at a time: no new item is taken until its closing status has been accepted;
// a close or a release forces one more pass while fewer than MaxEmit events are released.
// Reset (synchronous, active high) closes all slots and empties all queues.
module timestamp_merge_with_watermarks_core
   import tsm_pkg::*;
#(
   parameter int SOURCE_SLOTS = SourceSlotsDef,
   parameter int QUEUE_DEPTH  = QueueDepthDef
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // source_slot[1:0], start_time[33:2], event_kind[35:34], event_time[67:36],
   // event_tag[83:68], zero fill
   input  logic [87:0] req_tdata,
   // op[0]
   input  logic        req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_slot[1:0], out_time[33:2], out_tag[49:34], status[51:50], zero fill
   output logic [55:0] rsp_tdata,
   // result_kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int SLOTS = SOURCE_SLOTS;
   localparam int DEPTH = QUEUE_DEPTH;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);
   localparam int IW = (SW > 2) ? SW : 2;

   state_type state_ff, state_in;

   // per-slot control
   logic            open_ff  [SLOTS];
   logic [31:0]     start_ff [SLOTS];
   logic [PW-1:0]   hptr_ff  [SLOTS];
   logic [NW-1:0]   cnt_ff   [SLOTS];
   entry_type       head_ff  [SLOTS];   // copy of the queue head
   logic [1:0]      tailk_ff [SLOTS];   // kind at the queue tail

   // captured item
   logic            op_ff;
   logic [1:0]      slot_ff;
   logic [31:0]     st_ff;
   logic [1:0]      kind_ff;
   logic [31:0]     etime_ff;
   logic [15:0]     tag_ff;
   logic [1:0]      status_ff;

   // sequencer
   logic [CW-1:0]   s_ff;
   logic [CW-1:0]   o_ff;
   logic            blk_ff;
   logic            chg_ff;
   logic [EmitW-1:0] n_ff;

   // output register
   logic            out_kind_ff;
   logic [1:0]      out_slot_ff;
   logic [31:0]     out_time_ff;
   logic [15:0]     out_tag_ff;
   logic [1:0]      out_status_ff;
   logic            out_last_ff;
   logic            out_valid;

   // apply decode
   logic [IW-1:0]   slot_ext;
   logic            in_range;
   logic [SW-1:0]   aidx;
   logic [NW-1:0]   a_cnt, a_cnt2;
   logic            a_full;
   logic [NW:0]     a_sum;
   logic [PW-1:0]   a_wptr;
   logic [1:0]      a_kind;
   logic [1:0]      a_status;
   logic            wr_en;
   entry_type       wr_data;

   // pass decode
   logic [SW-1:0]   sidx, oidx;
   logic            s_done, o_last;
   logic [PW-1:0]   nptr;
   entry_type       rd_data;
   cmp_req_type     cmp_req;
   logic            cmp_blocks, blk_now;
   logic            in_fire;

   assign in_fire  = req_tvalid && req_tready;

   assign slot_ext = IW'(slot_ff);
   assign in_range = (int'(slot_ext) < SLOTS);
   assign aidx     = slot_ext[SW-1:0];

   always_comb begin
      a_cnt  = cnt_ff[aidx];
      // a pulse at the tail gives way to the new event
      a_cnt2 = (a_cnt != '0 && tailk_ff[aidx] == KindPulse) ? a_cnt - NW'(1) : a_cnt;
      a_full = (a_cnt2 == NW'(DEPTH));
      a_sum  = (NW+1)'(hptr_ff[aidx]) + (NW+1)'(a_cnt2);
      if (a_sum >= (NW+1)'(DEPTH)) begin
         a_wptr = PW'(a_sum - (NW+1)'(DEPTH));
      end else begin
         a_wptr = PW'(a_sum);
      end
      a_kind = (kind_ff == KindEnd || kind_ff == KindPulse) ? kind_ff : KindComplex;
      if (!in_range) begin
         a_status = StInactive;
      end else if (op_ff == OpOpen) begin
         a_status = open_ff[aidx] ? StOpen : StOk;
      end else if (!open_ff[aidx]) begin
         a_status = StInactive;
      end else if (a_full) begin
         a_status = StFull;
      end else begin
         a_status = StOk;
      end
   end

   assign wr_en = (state_ff == ST_APPLY) && in_range && (op_ff == OpAppend) &&
                  open_ff[aidx] && !a_full;
   assign wr_data = '{time_v: etime_ff, tag: tag_ff, kind: a_kind};

   assign sidx   = s_ff[SW-1:0];
   assign oidx   = o_ff[SW-1:0];
   assign s_done = (s_ff == CW'(SLOTS));
   assign o_last = (o_ff == CW'(SLOTS - 1));
   assign nptr   = (hptr_ff[sidx] == PW'(DEPTH - 1)) ? '0 : hptr_ff[sidx] + PW'(1);

   tsm_entry_mem #(
      .SLOTS(SLOTS),
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_slot (aidx),
      .wr_ptr  (a_wptr),
      .wr_data (wr_data),
      .rd_slot (sidx),
      .rd_ptr  (nptr),
      .rd_data (rd_data)
   );

   always_comb begin
      cmp_req.active     = open_ff[oidx] && (o_ff != s_ff);
      cmp_req.empty      = (cnt_ff[oidx] == '0);
      cmp_req.start_time = start_ff[oidx];
      cmp_req.head_time  = head_ff[oidx].time_v;
      cmp_req.cand_time  = head_ff[sidx].time_v;
   end

   tsm_blk_cmp u_cmp (
      .req    (cmp_req),
      .blocks (cmp_blocks)
   );

   assign blk_now = blk_ff || cmp_blocks;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_fire) state_in = ST_APPLY;
         end
         ST_APPLY: state_in = ST_PASS;
         ST_PASS: begin
            if (s_done) begin
               if (!(chg_ff && n_ff < EmitW'(MaxEmit))) state_in = ST_WAIT_LAST;
            end else if (open_ff[sidx] && cnt_ff[sidx] != '0 &&
                         head_ff[sidx].kind == KindComplex && n_ff < EmitW'(MaxEmit)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (o_last) state_in = blk_now ? ST_PASS : ST_WAIT_OUT;
         end
         ST_WAIT_OUT: begin
            if (rsp_tready) state_in = (cnt_ff[sidx] == NW'(1)) ? ST_PASS : ST_FETCH;
         end
         ST_FETCH: state_in = ST_PASS;
         ST_WAIT_LAST: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = 1'b0;
      out_valid  = 1'b0;
      case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_WAIT_OUT:  out_valid  = 1'b1;
         ST_WAIT_LAST: out_valid  = 1'b1;
         default: begin
            req_tready = 1'b0;
            out_valid  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < SLOTS; i++) begin
            open_ff[i] <= 1'b0;
            hptr_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         s_ff   <= '0;
         o_ff   <= '0;
         blk_ff <= 1'b0;
         chg_ff <= 1'b0;
         n_ff   <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (in_fire) begin
                  op_ff    <= req_tuser;
                  slot_ff  <= req_tdata[1:0];
                  st_ff    <= req_tdata[33:2];
                  kind_ff  <= req_tdata[35:34];
                  etime_ff <= req_tdata[67:36];
                  tag_ff   <= req_tdata[83:68];
               end
            end
            ST_APPLY: begin
               status_ff <= a_status;
               s_ff      <= '0;
               chg_ff    <= 1'b0;
               n_ff      <= '0;
               if (in_range) begin
                  if (op_ff == OpOpen) begin
                     if (!open_ff[aidx]) begin
                        open_ff[aidx]  <= 1'b1;
                        start_ff[aidx] <= st_ff;
                        hptr_ff[aidx]  <= '0;
                        cnt_ff[aidx]   <= '0;
                     end
                  end else if (open_ff[aidx] && !a_full) begin
                     cnt_ff[aidx]   <= a_cnt2 + NW'(1);
                     tailk_ff[aidx] <= a_kind;
                     if (a_cnt2 == '0) head_ff[aidx] <= wr_data;
                  end
               end
            end
            ST_PASS: begin
               if (s_done) begin
                  s_ff   <= '0;
                  chg_ff <= 1'b0;
               end else if (!open_ff[sidx] || cnt_ff[sidx] == '0 ||
                            head_ff[sidx].kind == KindPulse) begin
                  s_ff <= s_ff + CW'(1);
               end else if (head_ff[sidx].kind == KindEnd) begin
                  // end mark closes the slot and drops its queue
                  open_ff[sidx] <= 1'b0;
                  hptr_ff[sidx] <= '0;
                  cnt_ff[sidx]  <= '0;
                  chg_ff        <= 1'b1;
                  s_ff          <= s_ff + CW'(1);
               end else if (n_ff >= EmitW'(MaxEmit)) begin
                  s_ff <= s_ff + CW'(1);
               end else begin
                  o_ff   <= '0;
                  blk_ff <= 1'b0;
               end
            end
            ST_CHECK: begin
               blk_ff <= blk_now;
               o_ff   <= o_ff + CW'(1);
               if (o_last && blk_now) s_ff <= s_ff + CW'(1);
            end
            ST_WAIT_OUT: begin
               if (rsp_tready) begin
                  n_ff          <= n_ff + EmitW'(1);
                  chg_ff        <= 1'b1;
                  hptr_ff[sidx] <= nptr;
                  if (cnt_ff[sidx] == NW'(1)) begin
                     // queue drained: leave a pulse at the released time
                     head_ff[sidx]  <= '{time_v: head_ff[sidx].time_v, tag: 16'd0,
                                        kind: KindPulse};
                     tailk_ff[sidx] <= KindPulse;
                     s_ff           <= s_ff + CW'(1);
                  end else begin
                     cnt_ff[sidx] <= cnt_ff[sidx] - NW'(1);
                  end
               end
            end
            ST_FETCH: head_ff[sidx] <= rd_data;
            ST_WAIT_LAST: begin
            end
            default: begin
            end
         endcase
      end
   end

   // output register loads
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK && o_last && !blk_now) begin
         out_kind_ff   <= RkEvent;
         out_slot_ff   <= s_ff[1:0];
         out_time_ff   <= head_ff[sidx].time_v;
         out_tag_ff    <= head_ff[sidx].tag;
         out_status_ff <= StOk;
         out_last_ff   <= 1'b0;
      end else if (state_ff == ST_PASS && state_in == ST_WAIT_LAST) begin
         out_kind_ff   <= RkClose;
         out_slot_ff   <= slot_ff;
         out_time_ff   <= '0;
         out_tag_ff    <= '0;
         out_status_ff <= status_ff;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {4'b0, out_status_ff, out_tag_ff, out_time_ff, out_slot_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= EmitW'(MaxEmit))
      else $error("release count above limit");

   a_last_is_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == RkClose))
      else $error("last item is not a closing status");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is pending");

   a_close_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not ready after closing status");

endmodule

FILE: tb/sv/tb_timestamp_merge_with_watermarks_core.sv
// Testbench for the timestamp merge core: directed and random items, predicted results.
module tb_timestamp_merge_with_watermarks_core;
   import tsm_pkg::*;

   localparam int Slots = SourceSlotsDef;
   localparam int Depth = QueueDepthDef;

   typedef struct packed {
      logic        rk;
      logic [1:0]  slot;
      logic [31:0] tm;
      logic [15:0] tag;
      logic [1:0]  st;
      logic        lst;
   } merge_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   timestamp_merge_with_watermarks_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // predictor state
   logic        m_open [Slots];
   logic [31:0] m_start [Slots];
   entry_type   m_q [Slots][Depth];
   int          m_head [Slots];
   int          m_cnt [Slots];

   merge_out_type merged_q[$];
   int          n_errors;
   int          n_items;
   int          n_events;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int qpos(int s, int i);
      return (m_head[s] + i) % Depth;
   endfunction

   function automatic bit is_blocked(int s, logic [31:0] t);
      for (int o = 0; o < Slots; o++) begin
         if (o == s || !m_open[o]) continue;
         if (m_cnt[o] == 0) begin
            if (m_start[o] <= t) return 1'b1;
         end else if (t > m_q[o][qpos(o, 0)].time_v) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Applies one item to the predictor and queues its expected results.
   task automatic predict_merge(logic op, logic [1:0] slot, logic [31:0] st_time,
                                logic [1:0] kind, logic [31:0] ev_time,
                                logic [15:0] tag);
      logic [1:0] status;
      int         n;
      bit         changed;
      entry_type  e;
      merge_out_type r;
      status = StOk;
      n = 0;
      if (kind == 2'd3) kind = KindComplex;
      if (op == OpOpen) begin
         if (m_open[slot]) status = StOpen;
         else begin
            m_open[slot] = 1'b1;
            m_start[slot] = st_time;
            m_head[slot] = 0;
            m_cnt[slot] = 0;
         end
      end else if (!m_open[slot]) begin
         status = StInactive;
      end else begin
         if (m_cnt[slot] > 0 && m_q[slot][qpos(slot, m_cnt[slot] - 1)].kind == KindPulse)
            m_cnt[slot]--;
         if (m_cnt[slot] >= Depth) status = StFull;
         else begin
            m_q[slot][qpos(slot, m_cnt[slot])] = '{time_v: ev_time, tag: tag, kind: kind};
            m_cnt[slot]++;
         end
      end
      changed = 1'b1;
      while (changed && n < MaxEmit) begin
         changed = 1'b0;
         for (int s = 0; s < Slots; s++) begin
            if (!m_open[s]) continue;
            while (m_cnt[s] > 0) begin
               e = m_q[s][qpos(s, 0)];
               if (e.kind == KindEnd) begin
                  m_open[s] = 1'b0;
                  m_head[s] = 0;
                  m_cnt[s] = 0;
                  changed = 1'b1;
                  break;
               end
               if (e.kind == KindPulse) break;
               if (is_blocked(s, e.time_v) || n >= MaxEmit) break;
               r = '{rk: RkEvent, slot: s[1:0], tm: e.time_v, tag: e.tag, st: StOk, lst: 1'b0};
               merged_q = {merged_q, r};
               n++;
               n_events++;
               m_head[s] = (m_head[s] + 1) % Depth;
               m_cnt[s]--;
               changed = 1'b1;
               if (m_cnt[s] == 0) begin
                  m_q[s][qpos(s, 0)] = '{time_v: e.time_v, tag: 16'd0, kind: KindPulse};
                  m_cnt[s] = 1;
                  break;
               end
            end
         end
      end
      r = '{rk: RkClose, slot: slot, tm: 32'd0, tag: 16'd0, st: status, lst: 1'b1};
      merged_q = {merged_q, r};
   endtask

   // Sends one item, predicting at acceptance; valid stays high into the next item
   // unless an idle gap follows.
   task automatic send_item(logic op, logic [1:0] slot, logic [31:0] st_time,
                            logic [1:0] kind, logic [31:0] ev_time, logic [15:0] tag);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, tag, ev_time, kind, st_time, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_merge(op, slot, st_time, kind, ev_time, tag);
      n_items++;
   endtask

   // Receiver stalls
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      merge_out_type ex;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (merged_q.size() == 0) begin
            $error("unexpected result item: tdata %h", rsp_tdata);
            n_errors++;
         end else begin
            ex = merged_q.pop_front();
            if (rsp_tuser !== ex.rk) begin
               $error("result_kind: expected %0d, actual %0d", ex.rk, rsp_tuser);
               n_errors++;
            end
            if (rsp_tdata[1:0] !== ex.slot) begin
               $error("out_slot: expected %0d, actual %0d", ex.slot, rsp_tdata[1:0]);
               n_errors++;
            end
            if (rsp_tdata[33:2] !== ex.tm) begin
               $error("out_time: expected %h, actual %h", ex.tm, rsp_tdata[33:2]);
               n_errors++;
            end
            if (rsp_tdata[49:34] !== ex.tag) begin
               $error("out_tag: expected %h, actual %h", ex.tag, rsp_tdata[49:34]);
               n_errors++;
            end
            if (rsp_tdata[51:50] !== ex.st) begin
               $error("status: expected %0d, actual %0d", ex.st, rsp_tdata[51:50]);
               n_errors++;
            end
            if (rsp_tlast !== ex.lst) begin
               $error("last: expected %0d, actual %0d", ex.lst, rsp_tlast);
               n_errors++;
            end
         end
      end
   end

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (merged_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(OpAppend, 2'd0, 32'd0, KindComplex, 32'd5, 16'h1111);   // closed slot
      send_item(OpOpen, 2'd0, 32'd0, KindComplex, 32'd0, 16'd0);
      send_item(OpOpen, 2'd0, 32'hFFFFFFFF, KindComplex, 32'd0, 16'd0); // already open
      send_item(OpOpen, 2'd1, 32'hFFFFFFFF, KindComplex, 32'd0, 16'd0);
      send_item(OpAppend, 2'd0, 32'd0, KindComplex, 32'd10, 16'hFFFF);
      send_item(OpAppend, 2'd1, 32'd0, 2'd3, 32'hFFFFFFFF, 16'h0001);   // kind three
      send_item(OpAppend, 2'd0, 32'd0, KindPulse, 32'd20, 16'h0);
      send_item(OpAppend, 2'd0, 32'd0, KindComplex, 32'hFFFFFFFF, 16'h2222); // tie
      // fill slot 0 past its depth while the empty slot 2 holds it back
      send_item(OpOpen, 2'd2, 32'd0, KindComplex, 32'd0, 16'd0);
      for (int i = 0; i < Depth + 2; i++)
         send_item(OpAppend, 2'd0, 32'd0, KindComplex, 32'd100 + i, i[15:0]);
      send_item(OpAppend, 2'd2, 32'd0, KindEnd, 32'd0, 16'd0);          // release burst
      for (int s = 0; s < Slots; s++)
         send_item(OpAppend, s[1:0], 32'd0, KindEnd, 32'hFFFFFFFF, 16'd0);
      drain_results();
   endtask

   task automatic test_random(int count, bit quiet);
      logic [31:0] base;
      int          s;
      calm = quiet;
      base = $urandom_range(0, 1000);
      for (int i = 0; i < count; i++) begin
         s = $urandom_range(0, Slots - 1);
         case ($urandom_range(0, 19))
            0, 1, 2: send_item(OpOpen, s[1:0], base + $urandom_range(0, 40), 2'($urandom),
                               $urandom, 16'($urandom));
            3: send_item(OpAppend, s[1:0], $urandom, KindEnd, $urandom, 16'($urandom));
            4: send_item(1'($urandom), s[1:0], $urandom, 2'($urandom), $urandom,
                         16'($urandom));
            5, 6: send_item(OpAppend, s[1:0], $urandom, KindPulse,
                            base + $urandom_range(0, 60), 16'($urandom));
            default: begin
               send_item(OpAppend, s[1:0], $urandom, $urandom_range(0, 3) == 3 ? 2'd3
                         : KindComplex, base + $urandom_range(0, 60), 16'($urandom));
               if ($urandom_range(0, 7) == 0) base = base + $urandom_range(1, 30);
            end
         endcase
      end
      drain_results();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      n_errors = 0;
      n_items = 0;
      n_events = 0;
      calm = 1'b0;
      for (int s = 0; s < Slots; s++) begin
         m_open[s] = 1'b0;
         m_start[s] = '0;
         m_head[s] = 0;
         m_cnt[s] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(180, 1'b0);
      test_random(50, 1'b1);
      $display("covered %0d items, %0d reordered events released", n_items, n_events);
      if (n_errors == 0)
         $display("tb_timestamp_merge_with_watermarks_core: done, clean");
      else
         $display("tb_timestamp_merge_with_watermarks_core: done, errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_timestamp_merge_with_watermarks_core: done, errors");
      $finish;
   end

endmodule
